// ----- hw/rtl/ptsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ptsp_pkg
// Shared types and constants of the point to segment projection unit.
// ----------------------------------------------------------------------------
package ptsp_pkg;

	localparam int CW    = 24;          // coordinate width
	localparam int DF    = 15;          // direction fraction bits
	localparam int UW    = DF + 2;      // direction width
	localparam int LW    = CW + 1;      // segment length width
	localparam int GW    = CW + 1;      // gap width
	localparam int DW    = CW + 1;      // point minus start
	localparam int PW    = DW + UW;     // one dot product term
	localparam int DOTW  = PW + 1;      // dot product
	localparam int TRW   = DOTW - DF;   // rounded projection
	localparam int TW    = CW + 2;      // clamped projection, unsigned
	localparam int OXW   = UW + TW + 1; // direction times projection
	localparam int NXW   = CW + 4;      // unsaturated projected point
	localparam int EW    = NXW + 1;     // point minus projected point
	localparam int SQW   = 2 * EW;      // square of one axis
	localparam int NW    = SQW;         // gap radicand
	localparam int RB    = NW / 2;      // gap root bits
	localparam int RW    = RB + 2;      // gap root remainder
	localparam int IXW   = 8;           // register index width
	localparam int NREG  = 4;
	localparam int QDEPTH = 4;
	localparam int QAW   = $clog2(QDEPTH);
	localparam int ONE   = 1 << DF;

	localparam logic [IXW-1:0] REG_START_X = IXW'(0);
	localparam logic [IXW-1:0] REG_START_Y = IXW'(1);
	localparam logic [IXW-1:0] REG_END_X   = IXW'(2);
	localparam logic [IXW-1:0] REG_END_Y   = IXW'(3);

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic                 ray_mode;
	} ptsp_in_t;

	typedef struct packed {
		logic signed [CW-1:0] near_x;
		logic signed [CW-1:0] near_y;
		logic [GW-1:0]        gap;
		logic                 seg_ok;
	} ptsp_out_t;

	typedef struct packed {
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
		logic signed [UW-1:0] unit_x;
		logic signed [UW-1:0] unit_y;
		logic [LW-1:0]        seg_length;
		logic                 seg_ok;
	} ptsp_seg_t;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic [TW-1:0]        t;
	} ptsp_item_t;

	function automatic logic signed [CW-1:0] sat_coord(logic signed [NXW-1:0] v);
		logic signed [NXW-1:0] hi;
		logic signed [NXW-1:0] lo;
		hi = NXW'((1 << (CW - 1)) - 1);
		lo = -hi - NXW'(1);
		if (v > hi)
			return CW'(hi);
		else if (v < lo)
			return CW'(lo);
		else
			return CW'(v);
	endfunction

endpackage

// ----- hw/rtl/point_to_segment_projection_unit.sv -----
// ----------------------------------------------------------------------------
// point_to_segment_projection_unit
// Projects query points onto a configured segment and reports the
// nearest point and the distance to it.
// ----------------------------------------------------------------------------
// usage
//   write start_x, start_y, end_x, end_y through cfg_we/cfg_index/cfg_data
//   each endpoint write starts a derivation of length and direction that
//   holds in_stall high through setup, root steps, rounding and the x and
//   y divide steps for a nonzero segment, and up to rounding for a zero one
//   points enter on in_valid/in_stall, one transaction per cycle when unstalled
//   results leave on out_valid/out_stall in input order, one per point
//   a point passes through 3 front stages, the queue, 5 back
//   stages, 29 root stages and the output register
//   throughput is one point per cycle when unstalled, set by the pipelined root
//   a stalled output freezes the back part; the 4-entry queue and the
//   front keep taking points until the queue fills, then in_stall rises
//   reset clears endpoints to zero: direction (1,0), length 0, seg_ok 0
// ----------------------------------------------------------------------------
module point_to_segment_projection_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ptsp_pkg::IXW-1:0] cfg_index,
	input  logic [ptsp_pkg::CW-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  ptsp_pkg::ptsp_in_t       in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output ptsp_pkg::ptsp_out_t      out_data
);
	import ptsp_pkg::*;

	ptsp_seg_t  seg;
	logic       busy, q_full, q_empty, push, pop;
	ptsp_item_t push_item, q_item;

	ptsp_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seg       (seg),
		.busy      (busy)
	);

	ptsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.seg       (seg),
		.busy      (busy),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	ptsp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.rd_item (q_item),
		.empty   (q_empty),
		.full    (q_full)
	);

	ptsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/ptsp_setup.sv -----
// ----------------------------------------------------------------------------
// ptsp_setup
// Endpoint registers; derives segment length (bitwise root) and unit
// direction (restoring division, or (1,0) for a zero length) after every endpoint write.
// ----------------------------------------------------------------------------
module ptsp_setup (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [ptsp_pkg::IXW-1:0] cfg_index,
	input  logic [ptsp_pkg::CW-1:0]  cfg_data,
	output ptsp_pkg::ptsp_seg_t      seg,
	output logic                     busy
);
	import ptsp_pkg::*;

	localparam int SNW  = 2 * LW;
	localparam int DNW  = LW + DF + 3;
	localparam int QW   = 18;
	localparam int CNTW = 5;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIFF = 8'b0000_0010,
		ST_MUL  = 8'b0000_0100,
		ST_SUM  = 8'b0000_1000,
		ST_ROOT = 8'b0001_0000,
		ST_RND  = 8'b0010_0000,
		ST_DIVX = 8'b0100_0000,
		ST_DIVY = 8'b1000_0000
	} st_t;

	st_t                  st_q;
	logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q;
	logic signed [UW-1:0] ux_q, uy_q;
	logic [LW-1:0]        len_q;
	logic                 ok_q;
	logic [CNTW-1:0]      cnt_q;

	logic signed [LW-1:0] dx_q, dy_q;
	logic [SNW-1:0]       sqx_q, sqy_q, n_q;
	logic [LW+1:0]        rem_q;
	logic [LW-1:0]        root_q;
	logic [DNW-1:0]       num_q;
	logic [QW-1:0]        quo_q;

	logic signed [LW-1:0] dx_c, dy_c;
	logic [LW-1:0]        magx, magy, lroot;
	logic [LW+1:0]        remn, rtrial;
	logic                 rge;
	logic [DNW-1:0]       dtrial, num_next;
	logic                 dge;
	logic [QW-1:0]        qnext, qclamp;
	logic signed [UW-1:0] udir;
	logic                 dneg;

	function automatic logic [DNW-1:0] div_num(logic [LW-1:0] m, logic [LW-1:0] l);
		return (DNW'(m) << DF) + DNW'(l >> 1);
	endfunction

	assign dx_c   = LW'(ex_q) - LW'(sx_q);
	assign dy_c   = LW'(ey_q) - LW'(sy_q);
	assign magx   = dx_q[LW-1] ? $unsigned(-dx_q) : $unsigned(dx_q);
	assign magy   = dy_q[LW-1] ? $unsigned(-dy_q) : $unsigned(dy_q);

	assign remn   = {rem_q[LW-1:0], n_q[SNW-1 -: 2]};
	assign rtrial = {root_q, 2'b01};
	assign rge    = remn >= rtrial;
	assign lroot  = (rem_q > (LW+2)'(root_q)) ? root_q + LW'(1) : root_q;

	assign dtrial   = DNW'(len_q) << cnt_q;
	assign dge      = num_q >= dtrial;
	assign num_next = dge ? num_q - dtrial : num_q;
	assign qnext    = {quo_q[QW-2:0], dge};
	assign qclamp   = (qnext > QW'(ONE)) ? QW'(ONE) : qnext;
	assign dneg     = (st_q == ST_DIVX) ? dx_q[LW-1] : dy_q[LW-1];
	assign udir     = dneg ? -$signed(UW'(qclamp)) : $signed(UW'(qclamp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			sx_q  <= '0;
			sy_q  <= '0;
			ex_q  <= '0;
			ey_q  <= '0;
			ux_q  <= UW'(ONE);
			uy_q  <= '0;
			len_q <= '0;
			ok_q  <= 1'b0;
			cnt_q <= '0;
		end else if (cfg_we && cfg_index < IXW'(NREG)) begin
			case (cfg_index)
				REG_START_X: sx_q <= cfg_data;
				REG_START_Y: sy_q <= cfg_data;
				REG_END_X:   ex_q <= cfg_data;
				default:     ey_q <= cfg_data;
			endcase
			ok_q <= 1'b0;
			st_q <= ST_DIFF;
		end else begin
			case (st_q)
				ST_DIFF: st_q <= ST_MUL;
				ST_MUL:  st_q <= ST_SUM;
				ST_SUM: begin
					cnt_q <= CNTW'(LW - 1);
					st_q  <= ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == '0)
						st_q <= ST_RND;
					else
						cnt_q <= cnt_q - CNTW'(1);
				end
				ST_RND: begin
					len_q <= lroot;
					if (lroot == '0) begin
						ux_q <= UW'(ONE);
						uy_q <= '0;
						st_q <= ST_IDLE;
					end else begin
						cnt_q <= CNTW'(QW - 1);
						st_q  <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					if (cnt_q == '0) begin
						ux_q  <= udir;
						cnt_q <= CNTW'(QW - 1);
						st_q  <= ST_DIVY;
					end else
						cnt_q <= cnt_q - CNTW'(1);
				end
				ST_DIVY: begin
					if (cnt_q == '0) begin
						uy_q <= udir;
						ok_q <= 1'b1;
						st_q <= ST_IDLE;
					end else
						cnt_q <= cnt_q - CNTW'(1);
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_DIFF: begin
				dx_q <= dx_c;
				dy_q <= dy_c;
			end
			ST_MUL: begin
				sqx_q <= $unsigned(SNW'(dx_q) * SNW'(dx_q));
				sqy_q <= $unsigned(SNW'(dy_q) * SNW'(dy_q));
			end
			ST_SUM: begin
				n_q    <= sqx_q + sqy_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rem_q  <= rge ? remn - rtrial : remn;
				root_q <= {root_q[LW-2:0], rge};
				n_q    <= n_q << 2;
			end
			ST_RND: begin
				num_q <= div_num(magx, lroot);
				quo_q <= '0;
			end
			ST_DIVX: begin
				if (cnt_q == '0) begin
					num_q <= div_num(magy, len_q);
					quo_q <= '0;
				end else begin
					num_q <= num_next;
					quo_q <= qnext;
				end
			end
			ST_DIVY: begin
				num_q <= num_next;
				quo_q <= qnext;
			end
			default: ;
		endcase
	end

	assign seg.start_x    = sx_q;
	assign seg.start_y    = sy_q;
	assign seg.unit_x     = ux_q;
	assign seg.unit_y     = uy_q;
	assign seg.seg_length = len_q;
	assign seg.seg_ok     = ok_q;
	assign busy           = st_q != ST_IDLE;

endmodule

// ----- hw/rtl/ptsp_front.sv -----
// ----------------------------------------------------------------------------
// ptsp_front
// Accepts query points, forms the dot product with the direction and
// clamps the projection length; pushes the result into the queue.
// ----------------------------------------------------------------------------
module ptsp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ptsp_pkg::ptsp_in_t   in_data,
	input  ptsp_pkg::ptsp_seg_t  seg,
	input  logic                 busy,
	input  logic                 q_full,
	output logic                 push,
	output ptsp_pkg::ptsp_item_t push_item
);
	import ptsp_pkg::*;

	logic                   en, acc;
	logic                   v_s1, v_s2, v_s3;
	logic signed [CW-1:0]   px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic                   ray_s1, ray_s2;
	logic signed [DW-1:0]   ddx_s1, ddy_s1;
	logic signed [PW-1:0]   pxu_s2, pyu_s2;
	logic [TW-1:0]          t_s3;
	logic signed [DOTW-1:0] dot;
	logic signed [TRW-1:0]  tr, tc;

	assign en       = !v_s3 || !q_full;
	assign in_stall = busy || !en;
	assign acc      = in_valid && !in_stall;

	assign dot = DOTW'(pxu_s2) + DOTW'(pyu_s2);
	assign tr  = TRW'((dot + DOTW'(1 << (DF - 1))) >>> DF);

	always_comb begin
		if (!seg.seg_ok || tr < 0)
			tc = '0;
		else if (!ray_s2 && tr > TRW'(seg.seg_length))
			tc = TRW'(seg.seg_length);
		else
			tc = tr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= in_data.point_x;
			py_s1  <= in_data.point_y;
			ray_s1 <= in_data.ray_mode;
			ddx_s1 <= DW'(in_data.point_x) - DW'(seg.start_x);
			ddy_s1 <= DW'(in_data.point_y) - DW'(seg.start_y);

			px_s2  <= px_s1;
			py_s2  <= py_s1;
			ray_s2 <= ray_s1;
			pxu_s2 <= PW'(ddx_s1) * PW'(seg.unit_x);
			pyu_s2 <= PW'(ddy_s1) * PW'(seg.unit_y);

			px_s3  <= px_s2;
			py_s3  <= py_s2;
			t_s3   <= TW'($unsigned(tc));
		end
	end

	assign push              = v_s3 && !q_full;
	assign push_item.point_x = px_s3;
	assign push_item.point_y = py_s3;
	assign push_item.t       = t_s3;

endmodule

// ----- hw/rtl/ptsp_queue.sv -----
// ----------------------------------------------------------------------------
// ptsp_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module ptsp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ptsp_pkg::ptsp_item_t wr_item,
	input  logic                 pop,
	output ptsp_pkg::ptsp_item_t rd_item,
	output logic                 empty,
	output logic                 full
);
	import ptsp_pkg::*;

	ptsp_item_t     mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign empty   = cnt_q == '0;
	assign full    = cnt_q == (QAW+1)'(QDEPTH);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + QAW'(1);
			if (do_pop)
				rp_q <= rp_q + QAW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (QAW+1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wr_item;
	end

endmodule

// ----- hw/rtl/ptsp_back.sv -----
// ----------------------------------------------------------------------------
// ptsp_back
// Builds the projected point, saturates it, and takes the distance through
// a pipelined bitwise square root; holds the result in an output register.
// ----------------------------------------------------------------------------
module ptsp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptsp_pkg::ptsp_seg_t  seg,
	input  logic                 q_empty,
	input  ptsp_pkg::ptsp_item_t q_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ptsp_pkg::ptsp_out_t  out_data
);
	import ptsp_pkg::*;

	localparam int LAST = RB - 1;

	logic                  en;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [CW-1:0]  px_s1, py_s1, px_s2, py_s2;
	logic signed [OXW-1:0] ox_s1, oy_s1;
	logic signed [OXW-1:0] offx, offy;
	logic signed [NXW-1:0] nx_s2, ny_s2;
	logic signed [EW-1:0]  ex_s3, ey_s3;
	logic signed [CW-1:0]  nearx_s3, neary_s3, nearx_s4, neary_s4, nearx_s5, neary_s5;
	logic [SQW-1:0]        sqx_s4, sqy_s4;
	logic [NW-1:0]         n_s5;

	logic                  v_sk    [RB];
	logic [RW-1:0]         rem_sk  [RB];
	logic [RB-1:0]         root_sk [RB];
	logic [NW-1:0]         nsh_sk  [RB];
	logic signed [CW-1:0]  nx_sk   [RB];
	logic signed [CW-1:0]  ny_sk   [RB];

	logic [RB:0]           adj;
	logic [GW-1:0]         gap;
	logic                  out_valid_q;
	ptsp_out_t             out_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !q_empty;

	assign offx = (ox_s1 + OXW'(1 << (DF - 1))) >>> DF;
	assign offy = (oy_s1 + OXW'(1 << (DF - 1))) >>> DF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= q_item.point_x;
			py_s1    <= q_item.point_y;
			ox_s1    <= OXW'(seg.unit_x) * $signed(OXW'(q_item.t));
			oy_s1    <= OXW'(seg.unit_y) * $signed(OXW'(q_item.t));

			px_s2    <= px_s1;
			py_s2    <= py_s1;
			nx_s2    <= NXW'(seg.start_x) + NXW'(offx);
			ny_s2    <= NXW'(seg.start_y) + NXW'(offy);

			ex_s3    <= EW'(px_s2) - EW'(nx_s2);
			ey_s3    <= EW'(py_s2) - EW'(ny_s2);
			nearx_s3 <= sat_coord(nx_s2);
			neary_s3 <= sat_coord(ny_s2);

			sqx_s4   <= $unsigned(SQW'(ex_s3) * SQW'(ex_s3));
			sqy_s4   <= $unsigned(SQW'(ey_s3) * SQW'(ey_s3));
			nearx_s4 <= nearx_s3;
			neary_s4 <= neary_s3;

			n_s5     <= sqx_s4 + sqy_s4;
			nearx_s5 <= nearx_s4;
			neary_s5 <= neary_s4;
		end
	end

	for (genvar k = 0; k < RB; k++) begin : g_root
		logic [RW-1:0]        rin, remn, trial;
		logic [RB-1:0]        rtin;
		logic [NW-1:0]        nin;
		logic                 vin, ge;
		logic signed [CW-1:0] xin, yin;

		if (k == 0) begin : g_first
			assign rin  = '0;
			assign rtin = '0;
			assign nin  = n_s5;
			assign vin  = v_s5;
			assign xin  = nearx_s5;
			assign yin  = neary_s5;
		end else begin : g_next
			assign rin  = rem_sk[k-1];
			assign rtin = root_sk[k-1];
			assign nin  = nsh_sk[k-1];
			assign vin  = v_sk[k-1];
			assign xin  = nx_sk[k-1];
			assign yin  = ny_sk[k-1];
		end

		assign remn  = {rin[RW-3:0], nin[NW-1 -: 2]};
		assign trial = {rtin, 2'b01};
		assign ge    = remn >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sk[k] <= 1'b0;
			else if (en)
				v_sk[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k]  <= ge ? remn - trial : remn;
				root_sk[k] <= {rtin[RB-2:0], ge};
				nsh_sk[k]  <= nin << 2;
				nx_sk[k]   <= xin;
				ny_sk[k]   <= yin;
			end
		end
	end

	assign adj = (rem_sk[LAST] > RW'(root_sk[LAST])) ? (RB+1)'(root_sk[LAST]) + (RB+1)'(1)
		: (RB+1)'(root_sk[LAST]);
	assign gap = (adj > (RB+1)'({GW{1'b1}})) ? {GW{1'b1}} : GW'(adj);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= v_sk[LAST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.near_x <= nx_sk[LAST];
			out_q.near_y <= ny_sk[LAST];
			out_q.gap    <= gap;
			out_q.seg_ok <= seg.seg_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/ptsp_checker.sv -----
// ----------------------------------------------------------------------------
// ptsp_checker
// Port-level checks of the projection unit, bound to the top level.
// ----------------------------------------------------------------------------
module ptsp_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_we,
	input logic [ptsp_pkg::IXW-1:0] cfg_index,
	input logic                     in_valid,
	input logic                     in_stall,
	input ptsp_pkg::ptsp_in_t       in_data,
	input logic                     out_valid,
	input logic                     out_stall,
	input ptsp_pkg::ptsp_out_t      out_data
);
	import ptsp_pkg::*;

	logic reg_wr;
	assign reg_wr = cfg_we && cfg_index < IXW'(NREG);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr |=> in_stall)
		else $error("point taken during derivation");

	a_cfg_long: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wr |-> ##4 in_stall)
		else $error("derivation ended too early");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled input transaction changed");

endmodule

bind point_to_segment_projection_unit ptsp_checker u_ptsp_checker (.*);

// ----- test/point_to_segment_projection_unit_tb.sv -----
// ----------------------------------------------------------------------------
// point_to_segment_projection_unit_tb
// Self-checking bench: programs segments through the register port, streams
// query points with random idle and stall cycles on both channels, and
// compares every result against a bit-exact projection and distance model.
// ----------------------------------------------------------------------------
module point_to_segment_projection_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptsp_pkg::*;

	localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam longint GMAX = (64'sd1 <<< GW) - 1;
	localparam longint LIMIT = 400000;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [IXW-1:0]  cfg_index;
	logic [CW-1:0]   cfg_data;
	logic            in_valid;
	logic            in_stall;
	ptsp_in_t        in_data;
	logic            out_valid;
	logic            out_stall;
	ptsp_out_t       out_data;

	ptsp_out_t       pending_results[$];
	int              errors;
	longint          cycles;
	int              send_idle_pct;
	int              recv_stall_pct;

	// segment state
	longint          seg_sx, seg_sy, seg_ex, seg_ey, dir_x, dir_y;
	longint unsigned seg_len;

	point_to_segment_projection_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned abs_val(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned hypot_round(longint a, longint b);
		longint unsigned ma, mb, n, r, c, rem;
		logic [127:0] c2;
		ma = abs_val(a);
		mb = abs_val(b);
		n = ma * ma + mb * mb;
		r = 0;
		for (int bt = 41; bt >= 0; bt--) begin
			c = r | (64'd1 << bt);
			c2 = 128'(c) * 128'(c);
			if (c2 <= 128'(n))
				r = c;
		end
		rem = n - r * r;
		if (rem > r)
			r++;
		return r;
	endfunction

	function automatic longint clamp_coord(longint v);
		return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
	endfunction

	function automatic void derive_direction();
		longint dx, dy, q;
		dx = seg_ex - seg_sx;
		dy = seg_ey - seg_sy;
		seg_len = hypot_round(dx, dy);
		if (seg_len == 0) begin
			dir_x = ONE;
			dir_y = 0;
		end else begin
			q = ((abs_val(dx) << DF) + seg_len / 2) / seg_len;
			if (q > ONE)
				q = ONE;
			dir_x = (dx < 0) ? -q : q;
			q = ((abs_val(dy) << DF) + seg_len / 2) / seg_len;
			if (q > ONE)
				q = ONE;
			dir_y = (dy < 0) ? -q : q;
		end
	endfunction

	function automatic ptsp_out_t project_point(ptsp_in_t p);
		ptsp_out_t r;
		longint px, py, nx, ny, dot, t;
		longint unsigned g;
		px = longint'(p.point_x);
		py = longint'(p.point_y);
		nx = seg_sx;
		ny = seg_sy;
		if (seg_len != 0) begin
			dot = (px - seg_sx) * dir_x + (py - seg_sy) * dir_y;
			t = (dot + (64'sd1 <<< (DF - 1))) >>> DF;
			if (t < 0)
				t = 0;
			if (!p.ray_mode && t > longint'(seg_len))
				t = seg_len;
			nx = seg_sx + ((dir_x * t + (64'sd1 <<< (DF - 1))) >>> DF);
			ny = seg_sy + ((dir_y * t + (64'sd1 <<< (DF - 1))) >>> DF);
		end
		g = hypot_round(px - nx, py - ny);
		if (g > GMAX)
			g = GMAX;
		r.near_x = CW'(clamp_coord(nx));
		r.near_y = CW'(clamp_coord(ny));
		r.gap = GW'(g);
		r.seg_ok = (seg_len != 0);
		return r;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_reg(int idx, longint val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= IXW'(idx);
		cfg_data <= CW'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (IXW'(idx))
			REG_START_X: seg_sx = longint'(signed'(CW'(val)));
			REG_START_Y: seg_sy = longint'(signed'(CW'(val)));
			REG_END_X:   seg_ex = longint'(signed'(CW'(val)));
			REG_END_Y:   seg_ey = longint'(signed'(CW'(val)));
			default:     return;
		endcase
		derive_direction();
	endtask

	task automatic set_segment(longint sx, longint sy, longint ex, longint ey);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
	endtask

	task automatic send_point(longint x, longint y, bit ray);
		ptsp_in_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		p.point_x = CW'(x);
		p.point_y = CW'(y);
		p.ray_mode = ray;
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(project_point(p));
	endtask

	task automatic send_random_points(int n);
		longint k, x, y;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1)) begin
				x = longint'(signed'(CW'($urandom)));
				y = longint'(signed'(CW'($urandom)));
			end else begin
				k = $urandom_range(400);
				x = clamp_coord(seg_sx + (((seg_ex - seg_sx) * k) >>> 8)
					+ longint'($urandom_range(2048)) - 1024);
				y = clamp_coord(seg_sy + (((seg_ey - seg_sy) * k) >>> 8)
					+ longint'($urandom_range(2048)) - 1024);
			end
			send_point(x, y, $urandom_range(1));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		ptsp_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_data.near_x !== e.near_x) begin
					$error("near_x exp %0d got %0d", e.near_x, out_data.near_x);
					errors++;
				end
				if (out_data.near_y !== e.near_y) begin
					$error("near_y exp %0d got %0d", e.near_y, out_data.near_y);
					errors++;
				end
				if (out_data.gap !== e.gap) begin
					$error("gap exp %0d got %0d", e.gap, out_data.gap);
					errors++;
				end
				if (out_data.seg_ok !== e.seg_ok) begin
					$error("seg_ok exp %0d got %0d", e.seg_ok, out_data.seg_ok);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic test_reset_segment();
		send_point(0, 0, 0);
		send_point(CMAX, CMIN, 1);
		send_point(CMIN, CMAX, 0);
		send_point(CMAX, CMAX, 0);
	endtask

	task automatic test_directed();
		set_segment(0, 0, 256 * 100, 0);
		send_point(256 * 50, 256 * 30, 0);
		send_point(-256 * 20, 256 * 5, 0);
		send_point(256 * 300, -256 * 7, 0);
		send_point(256 * 300, -256 * 7, 1);
		set_segment(CMIN, CMIN, CMAX, CMAX);
		send_point(CMIN, CMAX, 0);
		send_point(CMAX, CMIN, 1);
		send_point(0, 0, 0);
		set_segment(CMAX, CMIN, CMAX - 1, CMIN + 1);
		send_point(CMIN, CMAX, 1);
		send_point(CMIN, CMIN, 1);
		send_point(CMAX, CMAX, 0);
		write_reg(255, 12345);
		write_reg(7, -1);
		send_point(0, 0, 0);
		set_segment(-5000, 7000, -5000, 7000);
		send_point(CMAX, CMAX, 0);
		send_point(CMIN, CMIN, 1);
		send_point(-5000, 7000, 0);
	endtask

	task automatic test_random(int sidle, int rstall);
		longint a, b;
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		for (int s = 0; s < 4; s++) begin
			a = longint'(signed'(CW'($urandom)));
			b = longint'(signed'(CW'($urandom)));
			if (s == 3)
				set_segment(a, b, a + $urandom_range(3), b);
			else if (s == 2)
				set_segment(a >>> 10, b >>> 10, longint'(signed'(CW'($urandom))) >>> 10, b >>> 12);
			else
				set_segment(a, b, longint'(signed'(CW'($urandom))),
					longint'(signed'(CW'($urandom))));
			send_random_points(154);
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		seg_sx = 0;
		seg_sy = 0;
		seg_ex = 0;
		seg_ey = 0;
		derive_direction();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_segment();
		test_directed();
		test_random(29, 73);
		test_random(73, 29);
		test_random(0, 0);
		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/ptsp_pkg.sv
hw/rtl/ptsp_setup.sv
hw/rtl/ptsp_front.sv
hw/rtl/ptsp_queue.sv
hw/rtl/ptsp_back.sv
hw/rtl/point_to_segment_projection_unit.sv
hw/rtl/ptsp_checker.sv
test/point_to_segment_projection_unit_tb.sv
